// ===== rtl/core/poly_pkg.sv =====
// ----------------------------------------------------------------------------
// poly_pkg
// Shared constants, codes and helpers of the polynomial evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package poly_pkg;

   localparam int MAX_DEGREE = 15;
   localparam int COEF_DEPTH = MAX_DEGREE + 1;
   localparam int IDX_W      = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;

   localparam int Q_W        = 32;
   localparam int MOP_W      = Q_W + 1;
   localparam int PROD_W     = Q_W + MOP_W;
   localparam int RND_W      = PROD_W - 16;
   localparam int SUM_W      = RND_W + 1;

   localparam int SQRT_STEPS = 24;
   localparam int SQRT_N_W   = 2 * SQRT_STEPS;
   localparam int SQRT_REM_W = SQRT_STEPS + 4;
   localparam int CNT_W      = 5;

   localparam int REQ_DATA_W = 104;
   localparam int RSP_DATA_W = 40;

   typedef enum logic [2:0] {
      OP_LOAD    = 3'd0,
      OP_P_X     = 3'd1,
      OP_P_SQRT  = 3'd2,
      OP_XB_P_X  = 3'd3,
      OP_P_XPB   = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK  = 2'd0,
      STATUS_NEG = 2'd1,
      STATUS_SAT = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQRT,
      ST_READ,
      ST_MUL,
      ST_ADD,
      ST_FMUL,
      ST_FADD,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [Q_W-1:0] value;
      logic           flag;
   } sat_type;

   function automatic sat_type sat32(input logic signed [SUM_W-1:0] v);
      sat_type r;
      if (v > SUM_W'(signed'(64'sh7FFF_FFFF))) begin
         r.value = 32'h7FFF_FFFF;
         r.flag  = 1'b1;
      end else if (v < SUM_W'(signed'(-64'sh8000_0000))) begin
         r.value = 32'h8000_0000;
         r.flag  = 1'b1;
      end else begin
         r.value = v[Q_W-1:0];
         r.flag  = 1'b0;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/poly_ram.sv =====
// ----------------------------------------------------------------------------
// poly_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module poly_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                             clock,
   input  wire logic                             wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  wire logic [WIDTH-1:0]                 wr_data,
   input  wire logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic      [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ===== rtl/core/polynomial_evaluator.sv =====
// load item: writes one coefficient, no result
// p(x) and p(x+b): READ, then MUL and ADD for each coefficient, then DONE to the result register
// p(sqrt x): the bit-serial root (SQRT) runs first; (x-b)p(x): FMUL and FADD follow
// one item at a time; each coefficient goes through the shared multiplier (MUL, then ADD)
// synchronous active-high reset clears degree, the coefficient valid bits and the valid flag of the output
// ----------------------------------------------------------------------------
// polynomial_evaluator
// Horner evaluation of a Q16.16 polynomial held in a coefficient RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module polynomial_evaluator
   import poly_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write_enable,
   input  wire logic [3:0]            csr_write_data,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // op[2:0], coef_index[6:3], coef_value[38:7], x_value[70:39], b_value[102:71]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // result_value[31:0], status[33:32]
   output logic [RSP_DATA_W-1:0]      rsp_tdata
);

   state_type                state_ff, state_in;
   logic [3:0]               degree_ff;
   logic [COEF_DEPTH-1:0]    valid_ff, valid_in;
   logic [2:0]               op_ff, op_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic signed [MOP_W-1:0]  mop_ff, mop_in;
   logic signed [MOP_W-1:0]  diff_ff, diff_in;
   logic signed [Q_W-1:0]    acc_ff, acc_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [Q_W-1:0]    coef_ff, coef_in;
   logic [SQRT_N_W-1:0]      sq_n_ff, sq_n_in;
   logic [SQRT_REM_W-1:0]    sq_rem_ff, sq_rem_in;
   logic [SQRT_STEPS-1:0]    sq_root_ff, sq_root_in;
   logic                     flag_ff, flag_in;
   logic                     neg_ff, neg_in;
   logic                     rd_valid_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [Q_W-1:0]           rsp_value_ff, rsp_value_in;
   logic [1:0]               rsp_status_ff, rsp_status_in;

   logic [2:0]               req_op;
   logic [3:0]               req_index;
   logic signed [Q_W-1:0]    req_coef;
   logic signed [Q_W-1:0]    req_x;
   logic signed [Q_W-1:0]    req_b;
   logic                     req_accept;
   logic                     out_free;
   logic [IDX_W-1:0]         top_idx;
   logic [IDX_W-1:0]         rd_addr;
   logic [Q_W-1:0]           ram_q;
   logic                     ram_we;
   logic signed [MOP_W-1:0]  mul_b;
   logic signed [PROD_W-1:0] rnd_full;
   logic signed [SUM_W-1:0]  step_sum;
   logic signed [SUM_W-1:0]  xpb_sum;
   sat_type                  step_sat;
   sat_type                  xpb_sat;
   logic [SQRT_REM_W-1:0]    sq_shift;
   logic [SQRT_REM_W-1:0]    sq_trial;

   assign req_op     = req_tdata[2:0];
   assign req_index  = req_tdata[6:3];
   assign req_coef   = req_tdata[38:7];
   assign req_x      = req_tdata[70:39];
   assign req_b      = req_tdata[102:71];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_status_ff, rsp_value_ff};

   assign top_idx = (32'(degree_ff) > MAX_DEGREE) ? IDX_W'(MAX_DEGREE) : IDX_W'(degree_ff);
   assign rd_addr = (state_ff == ST_ADD) ? idx_ff - IDX_W'(1) : idx_ff;
   assign ram_we  = req_accept && (req_op == OP_LOAD) && (32'(req_index) <= MAX_DEGREE);

   poly_ram #(
      .WIDTH (Q_W),
      .DEPTH (COEF_DEPTH)
   ) u_coef_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (IDX_W'(req_index)),
      .wr_data (req_coef),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // datapath helpers
   assign mul_b    = (state_ff == ST_FMUL) ? diff_ff : mop_ff;
   assign prod_in  = acc_ff * mul_b;
   assign rnd_full = prod_ff + PROD_W'(signed'(33'sh8000));
   assign step_sum = SUM_W'(signed'(rnd_full[PROD_W-1:16])) + SUM_W'(coef_ff);
   assign step_sat = sat32(step_sum);
   assign xpb_sum  = SUM_W'(req_x) + SUM_W'(req_b);
   assign xpb_sat  = sat32(xpb_sum);
   assign sq_shift = {sq_rem_ff[SQRT_REM_W-3:0], sq_n_ff[SQRT_N_W-1 -: 2]};
   assign sq_trial = SQRT_REM_W'({sq_root_ff, 2'b01});

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_op)
                  OP_P_X, OP_XB_P_X, OP_P_XPB: state_in = ST_READ;
                  OP_P_SQRT: state_in = req_x[Q_W-1] ? ST_DONE : ST_SQRT;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_SQRT: begin
            if (cnt_ff == CNT_W'(SQRT_STEPS - 1)) begin
               state_in = ST_READ;
            end
         end
         ST_READ: state_in = ST_MUL;
         ST_MUL:  state_in = ST_ADD;
         ST_ADD: begin
            if (idx_ff == '0) begin
               state_in = (op_ff == OP_XB_P_X) ? ST_FMUL : ST_DONE;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_FMUL: state_in = ST_FADD;
         ST_FADD: state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and output control
   always_comb begin
      valid_in      = valid_ff;
      op_in         = op_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      mop_in        = mop_ff;
      diff_in       = diff_ff;
      acc_in        = acc_ff;
      coef_in       = coef_ff;
      sq_n_in       = sq_n_ff;
      sq_rem_in     = sq_rem_ff;
      sq_root_in    = sq_root_ff;
      flag_in       = flag_ff;
      neg_in        = neg_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               op_in      = req_op;
               idx_in     = top_idx;
               cnt_in     = '0;
               acc_in     = '0;
               flag_in    = 1'b0;
               neg_in     = req_x[Q_W-1];
               diff_in    = MOP_W'(req_x) - MOP_W'(req_b);
               sq_n_in    = {req_x, 16'd0};
               sq_rem_in  = '0;
               sq_root_in = '0;
               if (req_op == OP_P_XPB) begin
                  mop_in  = MOP_W'(signed'(xpb_sat.value));
                  flag_in = xpb_sat.flag;
               end else begin
                  mop_in  = MOP_W'(req_x);
               end
               if (ram_we) begin
                  valid_in[IDX_W'(req_index)] = 1'b1;
               end
            end
         end
         ST_SQRT: begin
            cnt_in  = cnt_ff + CNT_W'(1);
            sq_n_in = {sq_n_ff[SQRT_N_W-3:0], 2'b00};
            if (sq_shift >= sq_trial) begin
               sq_rem_in  = sq_shift - sq_trial;
               sq_root_in = {sq_root_ff[SQRT_STEPS-2:0], 1'b1};
            end else begin
               sq_rem_in  = sq_shift;
               sq_root_in = {sq_root_ff[SQRT_STEPS-2:0], 1'b0};
            end
            mop_in = MOP_W'(sq_root_in);
         end
         ST_MUL: begin
            coef_in = rd_valid_ff ? ram_q : '0;
         end
         ST_ADD: begin
            acc_in  = step_sat.value;
            flag_in = flag_ff || step_sat.flag;
            idx_in  = idx_ff - IDX_W'(1);
         end
         ST_FMUL: begin
            coef_in = '0;
         end
         ST_FADD: begin
            acc_in  = step_sat.value;
            flag_in = flag_ff || step_sat.flag;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (neg_ff && (op_ff == OP_P_SQRT)) begin
                  rsp_value_in  = '0;
                  rsp_status_in = STATUS_NEG;
               end else begin
                  rsp_value_in  = acc_ff;
                  rsp_status_in = flag_ff ? STATUS_SAT : STATUS_OK;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         degree_ff    <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            degree_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      idx_ff        <= idx_in;
      cnt_ff        <= cnt_in;
      mop_ff        <= mop_in;
      diff_ff       <= diff_in;
      acc_ff        <= acc_in;
      prod_ff       <= prod_in;
      coef_ff       <= coef_in;
      sq_n_ff       <= sq_n_in;
      sq_rem_ff     <= sq_rem_in;
      sq_root_ff    <= sq_root_in;
      flag_ff       <= flag_in;
      neg_ff        <= neg_in;
      rd_valid_ff   <= valid_ff[rd_addr];
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   a_eval_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_op == OP_P_X || req_op == OP_XB_P_X || req_op == OP_P_XPB)
      |=> state_ff != ST_IDLE)
      else $error("evaluate item did not start");

   a_write_only_idle: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> state_ff == ST_IDLE)
      else $error("coefficient write while busy");

   a_sqrt_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SQRT |-> cnt_ff < CNT_W'(SQRT_STEPS))
      else $error("root step count overrun");

   a_neg_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == STATUS_NEG |-> rsp_value_ff == '0)
      else $error("negative root with nonzero value");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> rsp_valid_ff && $stable(rsp_value_ff))
      else $error("pending result lost");

endmodule

`default_nettype wire
